// ----- rtl/cursor_sequence_store_core_defines.svh -----
// cursor_sequence_store_core_defines.svh
// assertion macros shared by the cursor sequence store rtl
// no dependencies; take in with `include before the module
`ifndef CURSOR_SEQUENCE_STORE_CORE_DEFINES_SVH
`define CURSOR_SEQUENCE_STORE_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cursor store: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define CSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cursor store: next-cycle check failed");

`endif

// ----- rtl/csstore_pkg.sv -----
// csstore_pkg.sv
// types and fixed constants for the cursor sequence store
// no dependencies
`timescale 1ns / 1ps

package csstore_pkg;

    // fixed port widths
    localparam int KIND_W   = 3;
    localparam int PORT_W   = 32;
    localparam int COUNT_W  = 4;
    localparam int STATUS_W = 2;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        OP_START   = 3'd0,
        OP_ADVANCE = 3'd1,
        OP_INSERT  = 3'd2,
        OP_ATTACH  = 3'd3,
        OP_REMOVE  = 3'd4,
        OP_READ    = 3'd5
    } t_op_kind;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    // per-cell move control for one accepted beat
    typedef struct packed {
        logic load;        // take the new entry
        logic take_left;   // shift towards the back
        logic take_right;  // shift towards the front
    } t_cell_ctl;

endpackage

// ----- rtl/cursor_sequence_store_core.sv -----
// Cursor sequence store: an ordered list of up to CAPACITY entries with one
// cursor, driven by one operation per input beat (start, advance, insert
// before, attach after, remove, read) and answering each with one result beat.
// The row of entry cells shifts all positions at once, so a new beat is taken
// every cycle, and the result sits in an output register from the cycle after
// acceptance. Input is held off during reset and while that result register is
// full and stalled. Entries wider than 32 bits are cut to 32; entry_count
// reports the low 4 bits of the stored count.
// Depends on csstore_pkg, csstore_cell and cursor_sequence_store_core_defines.svh.
`timescale 1ns / 1ps
`include "cursor_sequence_store_core_defines.svh"

module cursor_sequence_store_core #(
    parameter int CAPACITY   = 8,
    parameter int ENTRY_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [csstore_pkg::KIND_W-1:0]      i_kind,
    input  logic [csstore_pkg::PORT_W-1:0]      i_entry_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [csstore_pkg::PORT_W-1:0]      o_current_value,
    output logic                                o_has_current,
    output logic [csstore_pkg::COUNT_W-1:0]     o_entry_count,
    output logic [csstore_pkg::STATUS_W-1:0]    o_status
);
    import csstore_pkg::*;

    localparam int EW = (ENTRY_BITS < PORT_W) ? ENTRY_BITS : PORT_W;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic                    w_accept;
    logic                    w_at_item;
    logic                    w_full;
    logic                    w_place;
    logic                    w_remove;
    logic [CW-1:0]           w_pos;
    logic [CW-1:0]           r_cursor;
    logic [CW-1:0]           n_cursor;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    t_status                 n_status;
    logic                    n_has_current;
    logic [EW-1:0]           w_new;
    logic [EW-1:0]           w_sel;
    t_cell_ctl               w_ctl  [CAPACITY];
    logic [EW-1:0]           w_next [CAPACITY];
    logic [EW-1:0]           w_data [CAPACITY];
    logic                    r_out_valid;
    logic [EW-1:0]           r_out_value;
    logic                    r_out_has;
    logic [COUNT_W-1:0]      r_out_count;
    t_status                 r_out_status;

    // handshake: take a beat whenever the result register will be free
    assign o_in_stall = !i_rst_n || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_at_item = r_cursor < r_count;
    assign w_full    = r_count >= CAP_CNT;
    assign w_new     = i_entry_value[EW-1:0];

    // operation decode
    always_comb begin
        n_cursor = r_cursor;
        n_count  = r_count;
        n_status = ST_OK;
        w_place  = 1'b0;
        w_remove = 1'b0;
        w_pos    = '0;
        unique case (i_kind)
            OP_START: begin
                n_cursor = '0;
            end
            OP_ADVANCE: begin
                if (w_at_item) begin
                    n_cursor = r_cursor + 1'b1;
                end else begin
                    n_status = ST_NONE;
                end
            end
            OP_INSERT, OP_ATTACH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_place = 1'b1;
                    if (i_kind == OP_INSERT) begin
                        w_pos = w_at_item ? r_cursor : '0;
                    end else begin
                        w_pos = w_at_item ? r_cursor + 1'b1 : r_count;
                    end
                    n_cursor = w_pos;
                    n_count  = r_count + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (w_at_item) begin
                    w_remove = 1'b1;
                    n_count  = r_count - 1'b1;
                end else begin
                    n_status = ST_NONE;
                end
            end
            OP_READ: begin
                if (!w_at_item) begin
                    n_status = ST_NONE;
                end
            end
            default: begin
            end
        endcase
    end

    // per-cell move controls, only on an accepted beat
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            w_ctl[k].load       = w_accept && w_place && (CW'(k) == w_pos);
            w_ctl[k].take_left  = w_accept && w_place && (CW'(k) > w_pos);
            w_ctl[k].take_right = w_accept && w_remove && (CW'(k) >= r_cursor)
                                  && (k < CAPACITY - 1);
        end
    end

    // row of entry cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [EW-1:0] w_left;
        logic [EW-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_data[g+1];
        end
        csstore_cell #(
            .EW (EW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_new   (w_new),
            .i_left  (w_left),
            .i_right (w_right),
            .o_next  (w_next[g]),
            .o_data  (w_data[g])
        );
    end

    // entry under the cursor after the operation
    assign n_has_current = n_cursor < n_count;
    always_comb begin
        w_sel = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (CW'(k) == n_cursor) begin
                w_sel = w_sel | w_next[k];
            end
        end
    end

    // list state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_cursor    <= n_cursor;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out_value  <= n_has_current ? w_sel : '0;
            r_out_has    <= n_has_current;
            r_out_count  <= COUNT_W'(n_count);
            r_out_status <= n_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_current_value = PORT_W'(r_out_value);
    assign o_has_current   = r_out_has;
    assign o_entry_count   = r_out_count;
    assign o_status        = r_out_status;

    // checks
    `CSS_ASSERT_SAME(a_cursor_in_list, i_clk, i_rst_n, 1'b1, r_cursor <= r_count)
    `CSS_ASSERT_SAME(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= CAP_CNT)
    `CSS_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_accept && w_place, r_count == $past(r_count) + 1'b1)
    `CSS_ASSERT_SAME(a_none_has_no_entry, i_clk, i_rst_n, r_out_valid && (r_out_status == ST_NONE), !o_has_current)

endmodule

// ----- rtl/csstore_cell.sv -----
// csstore_cell.sv
// one storage position of the entry row, fed by its two neighbours
// depends on csstore_pkg
`timescale 1ns / 1ps

module csstore_cell #(
    parameter int EW = 32
) (
    input  logic                   i_clk,
    input  csstore_pkg::t_cell_ctl i_ctl,
    input  logic [EW-1:0]          i_new,
    input  logic [EW-1:0]          i_left,
    input  logic [EW-1:0]          i_right,
    output logic [EW-1:0]          o_next,
    output logic [EW-1:0]          o_data
);
    import csstore_pkg::*;

    logic [EW-1:0] r_data;
    logic [EW-1:0] n_data;

    // pick the source for this position
    always_comb begin
        if (i_ctl.load) begin
            n_data = i_new;
        end else if (i_ctl.take_left) begin
            n_data = i_left;
        end else if (i_ctl.take_right) begin
            n_data = i_right;
        end else begin
            n_data = r_data;
        end
    end

    // entry storage, undefined until written
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_next = n_data;
    assign o_data = r_data;

endmodule

// ----- test/cursor_sequence_store_core_test.sv -----
// cursor_sequence_store_core_test.sv
// self-checking bench for cursor_sequence_store_core: directed table, then random beats
// depends on csstore_pkg and the cursor_sequence_store_core rtl
`timescale 1ns / 1ps

module cursor_sequence_store_core_test;

    import csstore_pkg::*;

    localparam int CAPACITY         = 8;
    localparam int RANDOM_PER_PHASE = 433;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 4;

    // kinds outside the operation set, taken as no-ops
    localparam logic [KIND_W-1:0] KIND_NOP_SIX   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_NOP_SEVEN = 3'd7;

    // one result beat as the block reports it
    typedef struct packed {
        logic [PORT_W-1:0]  current_value;
        logic               has_current;
        logic [COUNT_W-1:0] entry_count;
        t_status            status;
    } t_seq_result;

    // one row of the directed table
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PORT_W-1:0] value;
        logic              typed;
        t_seq_result       want;
    } t_drive_row;

    localparam t_seq_result NO_WANT = '{32'h0, 1'b0, 4'd0, ST_OK};

    localparam int DIRECTED_ROWS = 23;

    // directed stimulus; results typed in only where obvious
    localparam t_drive_row DIRECTED_TABLE [DIRECTED_ROWS] = '{
        '{OP_READ,        32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 4'd0, ST_NONE}},
        '{OP_ADVANCE,     32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 4'd0, ST_NONE}},
        '{OP_REMOVE,      32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 4'd0, ST_NONE}},
        '{OP_START,       32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 4'd0, ST_OK}},
        '{KIND_NOP_SIX,   32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 4'd0, ST_OK}},
        '{OP_INSERT,      32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1, 4'd1, ST_OK}},
        '{OP_REMOVE,      32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 4'd0, ST_OK}},
        '{OP_INSERT,      32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1, 4'd1, ST_OK}},
        '{OP_ATTACH,      32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 4'd2, ST_OK}},
        '{OP_ATTACH,      32'h8000_0000, 1'b0, NO_WANT},
        '{OP_INSERT,      32'h7FFF_FFFF, 1'b0, NO_WANT},
        '{OP_ATTACH,      32'h5555_5555, 1'b0, NO_WANT},
        '{OP_ATTACH,      32'hAAAA_AAAA, 1'b0, NO_WANT},
        '{OP_INSERT,      32'h0000_0001, 1'b0, NO_WANT},
        '{OP_ATTACH,      32'hFFFF_FFFE, 1'b1, '{32'hFFFF_FFFE, 1'b1, 4'd8, ST_OK}},
        '{OP_INSERT,      32'h1234_5678, 1'b1, '{32'hFFFF_FFFE, 1'b1, 4'd8, ST_FULL}},
        '{OP_ATTACH,      32'h1234_5678, 1'b1, '{32'hFFFF_FFFE, 1'b1, 4'd8, ST_FULL}},
        '{OP_START,       32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 4'd8, ST_OK}},
        '{OP_ADVANCE,     32'h0000_0000, 1'b0, NO_WANT},
        '{OP_REMOVE,      32'h0000_0000, 1'b0, NO_WANT},
        '{OP_READ,        32'h0000_0000, 1'b0, NO_WANT},
        '{KIND_NOP_SEVEN, 32'hDEAD_BEEF, 1'b0, NO_WANT},
        '{OP_ADVANCE,     32'h0000_0000, 1'b0, NO_WANT}
    };

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_stall;
    logic [KIND_W-1:0]   i_kind        = '0;
    logic [PORT_W-1:0]   i_entry_value = '0;
    logic                o_out_valid;
    logic                i_out_stall   = 1'b0;
    logic [PORT_W-1:0]   o_current_value;
    logic                o_has_current;
    logic [COUNT_W-1:0]  o_entry_count;
    logic [STATUS_W-1:0] o_status;

    // shadow of the list held by the predictor
    logic [PORT_W-1:0] seq_entries [CAPACITY];
    int unsigned       seq_count;
    int unsigned       seq_cursor;

    t_seq_result pending_results [$];
    int unsigned mismatch_count = 0;
    int unsigned in_idle_pct    = 0;
    int unsigned out_stall_pct  = 0;
    int unsigned cycle_count    = 0;

    cursor_sequence_store_core #(
        .CAPACITY   (CAPACITY),
        .ENTRY_BITS (32)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_entry_value   (i_entry_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_current_value (o_current_value),
        .o_has_current   (o_has_current),
        .o_entry_count   (o_entry_count),
        .o_status        (o_status)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // apply one operation to the shadow list and report what the block should show
    function automatic t_seq_result step_sequence(input logic [KIND_W-1:0] kind,
                                                  input logic [PORT_W-1:0] value);
        t_seq_result r;
        t_status     st;
        int unsigned slot;
        int unsigned i;
        st   = ST_OK;
        slot = 0;
        case (kind)
            OP_START: begin
                seq_cursor = 0;
            end
            OP_ADVANCE: begin
                if (seq_cursor < seq_count) seq_cursor++;
                else st = ST_NONE;
            end
            OP_INSERT, OP_ATTACH: begin
                if (seq_count >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    // insert goes before the cursor, attach after; front or back when none
                    if (seq_cursor < seq_count) begin
                        slot = (kind == OP_INSERT) ? seq_cursor : seq_cursor + 1;
                    end else begin
                        slot = (kind == OP_INSERT) ? 0 : seq_count;
                    end
                    for (i = seq_count; i > slot; i--) seq_entries[i] = seq_entries[i-1];
                    seq_entries[slot] = value;
                    seq_cursor = slot;
                    seq_count++;
                end
            end
            OP_REMOVE: begin
                if (seq_cursor < seq_count) begin
                    for (i = seq_cursor + 1; i < seq_count; i++) seq_entries[i-1] = seq_entries[i];
                    seq_count--;
                end else begin
                    st = ST_NONE;
                end
            end
            OP_READ: begin
                if (seq_cursor >= seq_count) st = ST_NONE;
            end
            default: begin
            end
        endcase
        if (seq_cursor < seq_count) begin
            r.current_value = seq_entries[seq_cursor];
            r.has_current   = 1'b1;
        end else begin
            r.current_value = '0;
            r.has_current   = 1'b0;
        end
        r.entry_count = COUNT_W'(seq_count);
        r.status      = st;
        return r;
    endfunction

    // offer one beat after a random gap, then record its expected result on acceptance
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [PORT_W-1:0] value,
                           input logic typed, input t_seq_result want);
        t_seq_result got;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_entry_value <= value;
        do @(posedge i_clk); while (o_in_stall);
        got = step_sequence(kind, value);
        pending_results.push_back(typed ? want : got);
    endtask

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_seq_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected result beat: value %h count %0d status %0d",
                         $time, o_current_value, o_entry_count, o_status);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_current_value !== exp_r.current_value) begin
                    mismatch_count++;
                    $display("%0t current_value expected %h actual %h",
                             $time, exp_r.current_value, o_current_value);
                end
                if (o_has_current !== exp_r.has_current) begin
                    mismatch_count++;
                    $display("%0t has_current expected %b actual %b",
                             $time, exp_r.has_current, o_has_current);
                end
                if (o_entry_count !== exp_r.entry_count) begin
                    mismatch_count++;
                    $display("%0t entry_count expected %0d actual %0d",
                             $time, exp_r.entry_count, o_entry_count);
                end
                if (o_status !== exp_r.status) begin
                    mismatch_count++;
                    $display("%0t status expected %0d actual %0d",
                             $time, exp_r.status, o_status);
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // stimulus
    initial begin
        logic [KIND_W-1:0] kind;
        logic [PORT_W-1:0] value;
        int unsigned       phase;
        int unsigned       counted;
        int unsigned       mode_left;
        int unsigned       roll;
        bit                filling;
        int                row;

        seq_count  = 0;
        seq_cursor = 0;
        mode_left  = 0;
        filling    = 1'b1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under the first idling mix
        in_idle_pct   = 31;
        out_stall_pct = 62;
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            send_op(DIRECTED_TABLE[row].kind, DIRECTED_TABLE[row].value,
                    DIRECTED_TABLE[row].typed, DIRECTED_TABLE[row].want);
        end

        // random beats in three phases, in randomly chosen stretches that fill or drain the list
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    in_idle_pct   = 31;
                    out_stall_pct = 62;
                end
                1: begin
                    in_idle_pct   = 62;
                    out_stall_pct = 31;
                end
                default: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                end
            endcase
            counted = 0;
            while (counted < RANDOM_PER_PHASE) begin
                if (mode_left == 0) begin
                    filling   = $urandom_range(1);
                    mode_left = $urandom_range(40, 10);
                end
                mode_left--;
                roll = $urandom_range(99);
                if (filling) begin
                    if (roll < 5)       kind = OP_START;
                    else if (roll < 25) kind = OP_ADVANCE;
                    else if (roll < 50) kind = OP_INSERT;
                    else if (roll < 75) kind = OP_ATTACH;
                    else if (roll < 85) kind = OP_REMOVE;
                    else if (roll < 95) kind = OP_READ;
                    else                kind = $urandom_range(1) ? KIND_NOP_SIX : KIND_NOP_SEVEN;
                end else begin
                    if (roll < 10)      kind = OP_START;
                    else if (roll < 25) kind = OP_ADVANCE;
                    else if (roll < 35) kind = OP_INSERT;
                    else if (roll < 45) kind = OP_ATTACH;
                    else if (roll < 80) kind = OP_REMOVE;
                    else if (roll < 95) kind = OP_READ;
                    else                kind = $urandom_range(1) ? KIND_NOP_SIX : KIND_NOP_SEVEN;
                end
                case ($urandom_range(9))
                    0:       value = '0;
                    1:       value = '1;
                    default: value = $urandom();
                endcase
                send_op(kind, value, 1'b0, NO_WANT);
                counted++;
            end
        end

        // let the last results drain
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/csstore_pkg.sv
rtl/csstore_cell.sv
rtl/cursor_sequence_store_core.sv
test/cursor_sequence_store_core_test.sv
